/* rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // data path widths
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 5;

  // default number of table entries
  localparam int unsigned EntriesDflt = 16;

  // capacity register after reset
  localparam logic [CfgW-1:0] CapResetVal = 5'd16;

  // result value of a lookup that misses
  localparam logic [DataW-1:0] MissValue = '1;

  // request kinds
  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  // decisions made by the lookup logic for one request
  typedef struct packed {
    logic hit;        // key present before the request
    logic write_kv;   // selected entry takes key and value
    logic age_all;    // every valid entry ages by one (fill of a free slot)
    logic age_below;  // entries more recent than the touched rank age by one
    logic occ_inc;    // a free slot gets filled
  } ctl_t;

  // command broadcast to every entry
  typedef struct packed {
    logic             fire;
    logic             write_kv;
    logic             age_all;
    logic             age_below;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/lru_key_value_cache_unit.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The cache takes one get or put request per clock cycle as long as the
// result side takes its transactions, and returns one result per request,
// in order. A request sits in the input register, where all entries compare
// its key in parallel and update their recency ranks, and its result is then
// captured in the result register and offered from there. The rate is set by
// the tag compare and rank update across all ENTRIES entries. The capacity
// register limits how many entries are filled before eviction starts; the
// user must see that it is written only while no request is in flight, as
// the block itself does not enforce this.
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = lkvc_pkg::EntriesDflt
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_wr_en_i,
  input  wire  [lkvc_pkg::CfgW-1:0]    cfg_wr_data_i,   // capacity
  // request stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [2*lkvc_pkg::DataW-1:0] s_axis_tdata,    // key, new_value
  input  wire                          s_axis_tuser,    // req_type
  // result stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [lkvc_pkg::DataW-1:0]   m_axis_tdata,    // value
  output logic                         m_axis_tuser     // hit
);

  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned DW     = lkvc_pkg::DataW;

  logic                   in_valid_q, in_valid_d;
  logic                   req_type_q;
  logic [DW-1:0]          key_q;
  logic [DW-1:0]          new_value_q;
  logic                   out_valid_q, out_valid_d;
  logic                   hit_q;
  logic [DW-1:0]          value_q;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic [lkvc_pkg::CfgW-1:0] cap_q;

  logic                   s_accept;
  logic                   fire;
  lkvc_pkg::ctl_t         ctl;
  lkvc_pkg::cmd_t         cmd;
  logic [ENTRIES-1:0]     sel;
  logic [RANK_W-1:0]      touch_rank;
  logic [DW-1:0]          result;
  logic [ENTRIES-1:0]     match;
  logic [ENTRIES-1:0]     valid;
  logic [ENTRIES-1:0][RANK_W-1:0] rank;
  logic [ENTRIES-1:0][DW-1:0]     value;

  // handshake
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_type_q  <= s_axis_tuser;
      key_q       <= s_axis_tdata[DW-1:0];
      new_value_q <= s_axis_tdata[2*DW-1:DW];
    end
  end

  // capacity register and occupancy count
  assign occ_d = (fire && ctl.occ_inc) ? occ_q + OCC_W'(1) : occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapResetVal;
      occ_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        cap_q <= cfg_wr_data_i;
      end
      occ_q <= occ_d;
    end
  end

  // entry table
  assign cmd.fire      = fire;
  assign cmd.write_kv  = ctl.write_kv;
  assign cmd.age_all   = ctl.age_all;
  assign cmd.age_below = ctl.age_below;
  assign cmd.key       = key_q;
  assign cmd.value     = new_value_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
    lkvc_entry #(
      .RANK_W (RANK_W)
    ) u_entry (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .sel_i        (sel[g]),
      .touch_rank_i (touch_rank),
      .match_o      (match[g]),
      .valid_o      (valid[g]),
      .rank_o       (rank[g]),
      .value_o      (value[g])
    );
  end

  // lookup and replacement decision
  lkvc_select #(
    .ENTRIES (ENTRIES),
    .RANK_W  (RANK_W),
    .OCC_W   (OCC_W)
  ) u_select (
    .req_type_i   (req_type_q),
    .new_value_i  (new_value_q),
    .capacity_i   (cap_q),
    .occ_i        (occ_q),
    .match_i      (match),
    .valid_i      (valid),
    .rank_i       (rank),
    .value_i      (value),
    .ctl_o        (ctl),
    .sel_o        (sel),
    .touch_rank_o (touch_rank),
    .result_o     (result)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q   <= ctl.hit;
      value_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = value_q;
  assign m_axis_tuser  = hit_q;

endmodule

`default_nettype wire

/* rtl/lkvc_entry.sv */
// ----------------------------------------------------------------------------
// lkvc_entry
// One cache entry: key, value, valid bit and recency rank with its own
// key compare and rank update.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_entry #(
  parameter int unsigned RANK_W = 4
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  lkvc_pkg::cmd_t                    cmd_i,
  input  wire                               sel_i,
  input  wire  [RANK_W-1:0]                 touch_rank_i,
  output logic                              match_o,
  output logic                              valid_o,
  output logic [RANK_W-1:0]                 rank_o,
  output logic [lkvc_pkg::DataW-1:0]        value_o
);

  logic                       valid_q, valid_d;
  logic [RANK_W-1:0]          rank_q, rank_d;
  logic [lkvc_pkg::DataW-1:0] key_q;
  logic [lkvc_pkg::DataW-1:0] value_q;

  // tag compare
  assign match_o = valid_q && (key_q == cmd_i.key);
  assign valid_o = valid_q;
  assign rank_o  = rank_q;
  assign value_o = value_q;

  // valid and recency update
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.fire) begin
      if (sel_i) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (valid_q &&
                   (cmd_i.age_all || (cmd_i.age_below && (rank_q < touch_rank_i)))) begin
        rank_d = rank_q + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  // key and value storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.fire && sel_i && cmd_i.write_kv) begin
      key_q   <= cmd_i.key;
      value_q <= cmd_i.value;
    end
  end

endmodule

`default_nettype wire

/* rtl/lkvc_select.sv */
// ----------------------------------------------------------------------------
// lkvc_select
// Lookup and replacement decision: hit detection, value read, free slot
// and least recent victim choice, result value.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_select #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned RANK_W  = 4,
  parameter int unsigned OCC_W   = 5
) (
  input  wire                                    req_type_i,
  input  wire  [lkvc_pkg::DataW-1:0]             new_value_i,
  input  wire  [lkvc_pkg::CfgW-1:0]              capacity_i,
  input  wire  [OCC_W-1:0]                       occ_i,
  input  wire  [ENTRIES-1:0]                     match_i,
  input  wire  [ENTRIES-1:0]                     valid_i,
  input  wire  [ENTRIES-1:0][RANK_W-1:0]         rank_i,
  input  wire  [ENTRIES-1:0][lkvc_pkg::DataW-1:0] value_i,
  output lkvc_pkg::ctl_t                         ctl_o,
  output logic [ENTRIES-1:0]                     sel_o,
  output logic [RANK_W-1:0]                      touch_rank_o,
  output logic [lkvc_pkg::DataW-1:0]             result_o
);

  localparam int unsigned CMP_W = (OCC_W > lkvc_pkg::CfgW) ? OCC_W : lkvc_pkg::CfgW;

  logic                       hit;
  logic                       is_put;
  logic                       fill;
  logic                       evict;
  logic                       any_free;
  logic [RANK_W-1:0]          hit_rank;
  logic [RANK_W-1:0]          lru_rank;
  logic [lkvc_pkg::DataW-1:0] hit_value;
  logic [ENTRIES-1:0]         free_vec;
  logic [ENTRIES-1:0]         free_oh;
  logic [ENTRIES-1:0]         victim_oh;
  logic [CMP_W-1:0]           cap_ext;
  logic [CMP_W-1:0]           cap_eff;

  assign is_put = (req_type_i == lkvc_pkg::ReqPut);
  assign hit    = |match_i;

  // read rank and value of the matching entry (keys are unique)
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_i[i]) begin
        hit_rank  = hit_rank | rank_i[i];
        hit_value = hit_value | value_i[i];
      end
    end
  end

  // valid ranks are 0 .. occ-1, so the least recent entry holds occ-1
  assign lru_rank = RANK_W'(occ_i - OCC_W'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = valid_i[i] && (rank_i[i] == lru_rank);
    end
  end

  // lowest free slot
  assign free_vec = ~valid_i;
  assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
  assign any_free = |free_vec;

  // capacity clamped to 1 .. ENTRIES
  assign cap_ext = CMP_W'(capacity_i);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // replacement decision
  assign fill  = is_put && !hit && (CMP_W'(occ_i) < cap_eff) && any_free;
  assign evict = is_put && !hit && !fill;

  always_comb begin
    if (hit) begin
      sel_o = match_i;
    end else if (fill) begin
      sel_o = free_oh;
    end else if (evict) begin
      sel_o = victim_oh;
    end else begin
      sel_o = '0;
    end
  end

  assign touch_rank_o    = hit ? hit_rank : lru_rank;
  assign ctl_o.hit       = hit;
  assign ctl_o.write_kv  = is_put;
  assign ctl_o.age_all   = fill;
  assign ctl_o.age_below = hit || evict;
  assign ctl_o.occ_inc   = fill;

  // result value
  always_comb begin
    if (is_put) begin
      result_o = new_value_i;
    end else if (hit) begin
      result_o = hit_value;
    end else begin
      result_o = lkvc_pkg::MissValue;
    end
  end

endmodule

`default_nettype wire

/* test/lru_key_value_cache_unit_tb.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb
// Self-checking bench for the LRU key/value cache. A scoreboard class keeps
// its own copy of the table (keys, values, recency ranks, fill count) and
// predicts hit flag and value for every request the cache accepts; results
// are compared in order. Stimulus walks through a series of capacity
// settings, including zero, saturation and a drop below the fill count,
// with keys drawn mostly from a small pool so hits and evictions are common.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DataW      = lkvc_pkg::DataW;
  localparam int CfgW       = lkvc_pkg::CfgW;
  localparam int Entries    = lkvc_pkg::EntriesDflt;
  localparam int RankW      = $clog2(Entries);
  localparam int QuietLimit = 500;
  localparam int PoolSize   = 24;
  localparam int MaxPrinted = 100;

  // one predicted response
  typedef struct {
    logic             hit;
    logic [DataW-1:0] value;
  } cache_result_t;

  // shadow copy of the cache table and the queue of predicted responses
  class lru_cache_scoreboard;
    logic [DataW-1:0] slot_key[Entries];
    logic [DataW-1:0] slot_value[Entries];
    bit               slot_valid[Entries];
    logic [RankW-1:0] slot_rank[Entries];
    logic [CfgW-1:0]  fill_count;
    logic [CfgW-1:0]  capacity;
    cache_result_t    expected_q[$];
    int               errors;

    function new();
      capacity   = lkvc_pkg::CapResetVal;
      fill_count = '0;
      errors     = 0;
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
    endfunction

    function void set_capacity(logic [CfgW-1:0] c);
      capacity = c;
    endfunction

    // capacity in force: zero acts as one, large values clamp to the table size
    function int usable_slots();
      if (capacity == 0) return 1;
      if (capacity > Entries) return Entries;
      return capacity;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // make slot s most recent, entries more recent than it age by one
    function void promote(int s);
      logic [RankW-1:0] r;
      r = slot_rank[s];
      for (int i = 0; i < Entries; i++)
        if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = '0;
    endfunction

    function int find_slot(logic [DataW-1:0] k);
      for (int i = 0; i < Entries; i++)
        if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    // accepted request transaction: update the shadow table, queue the response
    function void note_request(logic kind, logic [DataW-1:0] k, logic [DataW-1:0] v);
      int            s;
      int            free_slot;
      int            victim;
      cache_result_t res;
      s = find_slot(k);
      res.hit = (s >= 0);
      if (kind == lkvc_pkg::ReqGet) begin
        res.value = lkvc_pkg::MissValue;
        if (s >= 0) begin
          res.value = slot_value[s];
          promote(s);
        end
      end else begin
        res.value = v;
        if (s >= 0) begin
          promote(s);
          slot_value[s] = v;
        end else begin
          free_slot = -1;
          if (fill_count < usable_slots())
            for (int i = 0; i < Entries; i++)
              if (!slot_valid[i] && free_slot < 0) free_slot = i;
          if (free_slot >= 0) begin
            // fill a free slot, everything else ages
            for (int i = 0; i < Entries; i++)
              if (slot_valid[i]) slot_rank[i]++;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = k;
            slot_value[free_slot] = v;
            slot_rank[free_slot]  = '0;
            fill_count++;
          end else begin
            // replace the least recent entry
            victim = -1;
            for (int i = 0; i < Entries; i++)
              if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                victim = i;
            if (victim >= 0) begin
              promote(victim);
              slot_key[victim]   = k;
              slot_value[victim] = v;
            end
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function bit count_error();
      errors++;
      return errors <= MaxPrinted;
    endfunction

    // accepted response transaction: compare with the oldest prediction
    function void check_result(logic hit, logic [DataW-1:0] value);
      cache_result_t exp_res;
      if (expected_q.size() == 0) begin
        if (count_error())
          $display("%0t: unexpected response, expected none, actual hit %0b value %h",
                   $time, hit, value);
        return;
      end
      exp_res = expected_q.pop_front();
      if (hit !== exp_res.hit)
        if (count_error())
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, exp_res.hit, hit);
      if (value !== exp_res.value)
        if (count_error())
          $display("%0t: value mismatch, expected %h, actual %h",
                   $time, exp_res.value, value);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_wr_en_i;
  logic [CfgW-1:0]      cfg_wr_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [2*DataW-1:0]   s_axis_tdata;   // key, new_value
  logic                 s_axis_tuser;   // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DataW-1:0]     m_axis_tdata;   // value
  logic                 m_axis_tuser;   // hit

  lru_cache_scoreboard  cache_sb = new();
  bit                   send_gappy;
  bit                   recv_stally;
  int                   quiet_cycles;
  logic [DataW-1:0]     key_pool[PoolSize];

  lru_key_value_cache_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // monitor both streams and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) cache_sb.check_result(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        cache_sb.note_request(s_axis_tuser, s_axis_tdata[DataW-1:0],
                              s_axis_tdata[2*DataW-1:DataW]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          cfg_wr_en_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("lru_key_value_cache_unit_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // response side, random stalls per transaction
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = recv_stally ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // drive one request, entered and left at a falling edge
  task automatic send_req(logic kind, logic [DataW-1:0] k, logic [DataW-1:0] v);
    int gap;
    gap = send_gappy ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {v, k};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // hold requests until every predicted response has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cache_sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CfgW-1:0] c);
    drain();
    // pipeline is two deep, let it settle
    repeat (3) @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= c;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    cache_sb.set_capacity(c);
  endtask

  function automatic logic [DataW-1:0] corner_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // random requests over a key pool sized a little above the capacity
  task automatic run_random(int count);
    int               pool_n;
    logic [DataW-1:0] k;
    logic [DataW-1:0] v;
    logic             kind;
    pool_n = cache_sb.usable_slots() + $urandom_range(0, 4);
    repeat (4) key_pool[$urandom_range(0, PoolSize-1)] = $urandom();
    send_gappy  = $urandom_range(0, 2) != 0;
    recv_stally = $urandom_range(0, 2) != 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 47) == 0) begin
        send_gappy  = $urandom_range(0, 1);
        recv_stally = $urandom_range(0, 1);
      end
      case ($urandom_range(0, 9))
        0:       k = $urandom();
        1:       k = corner_word();
        default: k = key_pool[$urandom_range(0, pool_n-1)];
      endcase
      v    = ($urandom_range(0, 7) == 0) ? corner_word() : $urandom();
      kind = $urandom_range(0, 1) ? lkvc_pkg::ReqPut : lkvc_pkg::ReqGet;
      send_req(kind, k, v);
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] phase_cap[11];
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = lkvc_pkg::ReqGet;
    m_axis_tready = 1'b0;
    quiet_cycles  = 0;
    send_gappy    = 1'b0;
    recv_stally   = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    // capacities ramp up so the fill path runs at several sizes, then drop below
    // the fill count and end on the extremes
    phase_cap = '{5'd1, 5'd2, 5'd5, 5'd8, 5'd31, 5'd16, 5'd3, 5'd12, 5'd17, 5'd0, 5'd16};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: capacity zero acts as a single entry
    write_capacity(5'd0);
    send_req(lkvc_pkg::ReqGet, 32'h0000_0000, 32'hFFFF_FFFF);  // miss on empty table
    send_req(lkvc_pkg::ReqPut, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(lkvc_pkg::ReqGet, 32'h8000_0000, 32'h0000_0000);  // hit
    send_req(lkvc_pkg::ReqPut, 32'h7FFF_FFFF, 32'h8000_0000);  // evicts the only entry
    send_req(lkvc_pkg::ReqGet, 32'h8000_0000, 32'h0000_0000);  // miss after eviction
    send_req(lkvc_pkg::ReqGet, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(lkvc_pkg::ReqPut, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  // overwrite with all ones
    send_req(lkvc_pkg::ReqGet, 32'h7FFF_FFFF, 32'h1234_5678);  // hit that returns all ones
    send_req(lkvc_pkg::ReqPut, 32'h0000_0000, 32'h0000_0000);
    send_req(lkvc_pkg::ReqGet, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(lkvc_pkg::ReqGet, 32'hFFFF_FFFF, 32'h0000_0000);

    foreach (phase_cap[p]) begin
      write_capacity(phase_cap[p]);
      run_random(118);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (cache_sb.errors == 0 && cache_sb.pending() == 0) begin
      $display("lru_key_value_cache_unit_tb: done, clean");
    end else begin
      $display("lru_key_value_cache_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
